// ===== sv/pdct_pkg.sv =====
// Package for the PD controller with cubic trajectory: word types, register
// indexes, reset values and datapath widths.
// Depends on nothing; every other file imports it.
package pdct_pkg;

  // Fixed-point format of angles, rates, gains and times
  localparam int FRAC_BITS = 16;

  // Trajectory fraction is Q30 whatever the format
  localparam int Q30_BITS   = 30;
  localparam int RATE_SHIFT = Q30_BITS - FRAC_BITS;

  // Rate dividend after the Q30-to-Q shift
  localparam int DD_W = 63 - RATE_SHIFT;

  // Magnitude of one gain term, and the signed sum of two
  localparam int PROD_W = 63 - FRAC_BITS;
  localparam int TERM_W = PROD_W + 2;

  // Restoring divider: one quotient bit per stage
  localparam int DIV_STEPS = 32;

  // APB address: five word registers
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [30:0] ONE30   = 31'd1 << Q30_BITS;
  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Register reset values
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] TARGET_RND = (PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> RATE_SHIFT;
  localparam logic [30:0] PROP_GAIN_RST    = 31'(1 << FRAC_BITS);
  localparam logic [30:0] DERIV_GAIN_RST   = 31'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [31:0] FINAL_TIME_RST   = 32'(1 << (FRAC_BITS - 1));
  localparam logic [31:0] START_ANGLE_RST  = 32'd0;
  localparam logic [31:0] TARGET_ANGLE_RST = TARGET_RND[31:0];

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_FINAL_TIME   = 3'd2,
    REG_START_ANGLE  = 3'd3,
    REG_TARGET_ANGLE = 3'd4
  } reg_index_t;

  // Input word
  typedef struct packed {
    logic        [31:0] now_time;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
  } sample_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] drive_torque;
    logic signed [31:0] desired_angle;
    logic signed [31:0] desired_rate;
    logic               saturated;
  } drive_t;

  // Flags and operands that ride alongside a division
  typedef struct packed {
    logic               hold;
    logic               full;
    logic               ovf;
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic signed [31:0] pos;
  } side_t;

endpackage

// ===== sv/pd_controller_cubic_trajectory_core.sv =====
// PD controller driven by a cubic point-to-point trajectory, Q16.16 datapath.
// Throughput: one word per cycle unless a stalled result word holds the pipeline;
// two 32-stage restoring dividers (time fraction, then rate) and four 32x32-class
// multiplier stages set the depth.
// Reset (synchronous): registers take their defaults, pipeline empties at once.
// Depends on pdct_pkg and pdct_div.
module pd_controller_cubic_trajectory_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  pdct_pkg::sample_t            sample,
  output logic                         drive_valid,
  input  logic                         drive_stall,
  output pdct_pkg::drive_t             drive,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pdct_pkg::*;

  // Configuration registers
  logic [30:0] prop_gain;
  logic [30:0] deriv_gain;
  logic [31:0] final_time;
  logic [31:0] start_angle;
  logic [31:0] target_angle;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Span of the move, derived from the angle registers
  logic [32:0] span;
  logic [32:0] span_mag;
  logic        span_neg;

  logic en;

  // Stage A: registered sample
  logic    a_valid;
  sample_t a_smp;
  logic    a_hold;
  logic    a_full;
  logic [31:0] d1_hi;
  side_t   d1_tag;

  logic        d1_valid;
  logic [31:0] d1_quot;
  side_t       d1_side;

  // Stages B..G: polynomial and position
  logic        b_valid, c_valid, d_valid, e_valid, f_valid, g_valid;
  side_t       b_side, c_side, d_side, e_side, f_side, g_side;
  logic [30:0] b_s;
  logic [30:0] c_s, c_s2;
  logic [28:0] c_g;
  logic [30:0] d_s2, d_s3;
  logic [61:0] d_mg;
  logic [30:0] e_h;
  logic [DD_W-1:0] e_dd, f_dd, g_dd;
  logic [32:0] f_pm;
  logic [31:0] g_pos;
  logic        g_ovf;

  logic [61:0] sq_prod_next;
  logic [61:0] g_prod_next;
  logic [61:0] s3_prod_next;
  logic [61:0] mg_prod_next;
  logic [33:0] h_raw_next;
  logic [30:0] h_next;
  logic [63:0] six_mg_next;
  logic [63:0] pm_prod_next;
  logic [33:0] pos_sum_next;

  logic [31:0] d2_hi;
  side_t       d2_tag;
  logic        d2_valid;
  logic [31:0] d2_quot;
  side_t       d2_side;

  // Stages H..K: rate, errors, gains, output
  logic        h_valid, i_valid, j_valid;
  side_t       h_side;
  logic [31:0] h_vel;
  logic        h_sat;
  logic [31:0] vel_next;
  logic        vel_sat_next;
  logic [32:0] e1_next, e2_next;
  logic [32:0] i_m1, i_m2;
  logic        i_n1, i_n2;
  logic [31:0] i_pos, i_vel;
  logic        i_sat;
  logic [63:0] p1_next, p2_next;
  logic [PROD_W-1:0] j_p1, j_p2;
  logic        j_n1, j_n2;
  logic [31:0] j_pos, j_vel;
  logic        j_sat;
  logic [TERM_W-1:0] t1_next, t2_next, sum_next;
  logic [TERM_W-32:0] upper_next;
  logic        fits_next;
  logic [31:0] torque_next;

  // APB port: always ready, written on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      final_time   <= FINAL_TIME_RST;
      start_angle  <= START_ANGLE_RST;
      target_angle <= TARGET_ANGLE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:    prop_gain    <= pwdata[30:0];
        REG_DERIV_GAIN:   deriv_gain   <= pwdata[30:0];
        REG_FINAL_TIME:   final_time   <= pwdata;
        REG_START_ANGLE:  start_angle  <= pwdata;
        REG_TARGET_ANGLE: target_angle <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_PROP_GAIN:    prdata = {1'b0, prop_gain};
      REG_DERIV_GAIN:   prdata = {1'b0, deriv_gain};
      REG_FINAL_TIME:   prdata = final_time;
      REG_START_ANGLE:  prdata = start_angle;
      REG_TARGET_ANGLE: prdata = target_angle;
      default:          prdata = '0;
    endcase
  end

  // Track the span magnitude and direction
  assign span = {target_angle[31], target_angle} - {start_angle[31], start_angle};

  always_ff @(posedge clk) begin
    span_neg <= span[32];
    span_mag <= span[32] ? (33'd0 - span) : span;
  end

  // Whole pipeline holds while a result word waits
  assign en           = !(drive_valid && drive_stall);
  assign sample_stall = !en;

  // Stage A: decide finished move, load the time divider
  assign a_hold = (final_time == '0) || (a_smp.now_time > final_time);
  assign a_full = (a_smp.now_time == final_time);
  assign d1_hi  = (a_hold || a_full) ? '0 : a_smp.now_time;

  always_comb begin
    d1_tag       = '0;
    d1_tag.hold  = a_hold;
    d1_tag.full  = a_full;
    d1_tag.angle = a_smp.measured_angle;
    d1_tag.rate  = a_smp.measured_rate;
  end

  // Time fraction: now_time * 2^32 / final_time
  pdct_div u_div_time (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .item_valid  (a_valid),
    .dividend_hi (d1_hi),
    .dividend_lo (32'd0),
    .divisor     (final_time),
    .tag         (d1_tag),
    .quot_valid  (d1_valid),
    .quotient    (d1_quot),
    .quot_tag    (d1_side)
  );

  // Polynomial products and position
  always_comb begin
    sq_prod_next = 62'(b_s) * 62'(b_s);
    g_prod_next  = 62'(b_s) * 62'(ONE30 - b_s);
    s3_prod_next = 62'(c_s2) * 62'(c_s);
    mg_prod_next = 62'(span_mag) * 62'(c_g);
    // Smoothstep 3s^2 - 2s^3, clipped to [0, 1]
    h_raw_next   = ({3'b000, d_s2} + {2'b00, d_s2, 1'b0}) - {2'b00, d_s3, 1'b0};
    if (h_raw_next[33]) begin
      h_next = '0;
    end else if (h_raw_next > 34'(ONE30)) begin
      h_next = ONE30;
    end else begin
      h_next = h_raw_next[30:0];
    end
    six_mg_next  = {d_mg, 2'b00} + {1'b0, d_mg, 1'b0};
    pm_prod_next = 64'(span_mag) * 64'(e_h);
    if (span_neg) begin
      pos_sum_next = {{2{start_angle[31]}}, start_angle} - {1'b0, f_pm};
    end else begin
      pos_sum_next = {{2{start_angle[31]}}, start_angle} + {1'b0, f_pm};
    end
  end

  // Load the rate divider; an oversize quotient bypasses it
  assign d2_hi = (g_side.hold || g_ovf) ? '0 : 32'(g_dd[DD_W-1:32]);

  always_comb begin
    d2_tag     = g_side;
    d2_tag.ovf = g_ovf;
    d2_tag.pos = g_pos;
  end

  // Rate: 6*|span|*s*(1-s) / final_time, in Q format
  pdct_div u_div_rate (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .item_valid  (g_valid),
    .dividend_hi (d2_hi),
    .dividend_lo (g_dd[31:0]),
    .divisor     (final_time),
    .tag         (d2_tag),
    .quot_valid  (d2_valid),
    .quotient    (d2_quot),
    .quot_tag    (d2_side)
  );

  // Signed, saturated rate
  always_comb begin
    vel_next     = '0;
    vel_sat_next = 1'b0;
    if (d2_side.hold) begin
      vel_next = '0;
    end else if (d2_side.ovf) begin
      vel_sat_next = 1'b1;
      vel_next     = span_neg ? SAT_MIN : SAT_MAX;
    end else if (span_neg) begin
      if (d2_quot[31] && (|d2_quot[30:0])) begin
        vel_sat_next = 1'b1;
        vel_next     = SAT_MIN;
      end else begin
        vel_next = 32'd0 - d2_quot;
      end
    end else begin
      if (d2_quot[31]) begin
        vel_sat_next = 1'b1;
        vel_next     = SAT_MAX;
      end else begin
        vel_next = d2_quot;
      end
    end
  end

  // Errors, gain products, sum and clip
  always_comb begin
    e1_next = {h_side.pos[31], h_side.pos} - {h_side.angle[31], h_side.angle};
    e2_next = {h_vel[31], h_vel} - {h_side.rate[31], h_side.rate};
    p1_next = 64'(prop_gain) * 64'(i_m1);
    p2_next = 64'(deriv_gain) * 64'(i_m2);
    t1_next = j_n1 ? ('0 - {2'b00, j_p1}) : {2'b00, j_p1};
    t2_next = j_n2 ? ('0 - {2'b00, j_p2}) : {2'b00, j_p2};
    sum_next   = t1_next + t2_next;
    upper_next = sum_next[TERM_W-1:31];
    fits_next  = (&upper_next) || !(|upper_next);
    if (fits_next) begin
      torque_next = sum_next[31:0];
    end else begin
      torque_next = sum_next[TERM_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      d_valid     <= 1'b0;
      e_valid     <= 1'b0;
      f_valid     <= 1'b0;
      g_valid     <= 1'b0;
      h_valid     <= 1'b0;
      i_valid     <= 1'b0;
      j_valid     <= 1'b0;
      drive_valid <= 1'b0;
    end else if (en) begin
      a_valid     <= sample_valid;
      b_valid     <= d1_valid;
      c_valid     <= b_valid;
      d_valid     <= c_valid;
      e_valid     <= d_valid;
      f_valid     <= e_valid;
      g_valid     <= f_valid;
      h_valid     <= d2_valid;
      i_valid     <= h_valid;
      j_valid     <= i_valid;
      drive_valid <= j_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_smp  <= sample;
      // B: Q30 fraction, exactly one at the end time
      b_side <= d1_side;
      b_s    <= d1_side.full ? ONE30 : {1'b0, d1_quot[31:2]};
      // C: s^2 and s(1-s)
      c_side <= b_side;
      c_s    <= b_s;
      c_s2   <= sq_prod_next[60:30];
      c_g    <= g_prod_next[58:30];
      // D: s^3 and |span|*s(1-s)
      d_side <= c_side;
      d_s2   <= c_s2;
      d_s3   <= s3_prod_next[60:30];
      d_mg   <= mg_prod_next;
      // E: smoothstep and scaled rate dividend
      e_side <= d_side;
      e_h    <= h_next;
      e_dd   <= six_mg_next[62:RATE_SHIFT];
      // F: position offset
      f_side <= e_side;
      f_pm   <= pm_prod_next[62:30];
      f_dd   <= e_dd;
      // G: position, overflow check for the rate quotient
      g_side <= f_side;
      g_pos  <= f_side.hold ? target_angle : pos_sum_next[31:0];
      g_ovf  <= 32'(f_dd[DD_W-1:32]) >= final_time;
      g_dd   <= f_dd;
      // H: rate
      h_side <= d2_side;
      h_vel  <= vel_next;
      h_sat  <= vel_sat_next;
      // I: error magnitudes and signs
      i_n1   <= e1_next[32];
      i_m1   <= e1_next[32] ? (33'd0 - e1_next) : e1_next;
      i_n2   <= e2_next[32];
      i_m2   <= e2_next[32] ? (33'd0 - e2_next) : e2_next;
      i_pos  <= h_side.pos;
      i_vel  <= h_vel;
      i_sat  <= h_sat;
      // J: gain terms
      j_p1   <= p1_next[62:FRAC_BITS];
      j_p2   <= p2_next[62:FRAC_BITS];
      j_n1   <= i_n1;
      j_n2   <= i_n2;
      j_pos  <= i_pos;
      j_vel  <= i_vel;
      j_sat  <= i_sat;
      // K: result word
      drive.drive_torque  <= torque_next;
      drive.desired_angle <= j_pos;
      drive.desired_rate  <= j_vel;
      drive.saturated     <= j_sat || !fits_next;
    end
  end

`ifndef SYNTHESIS
  // Input is held back only by a waiting result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> drive_valid && drive_stall)
    else $error("sample stalled without a stalled result word");

  // An unclipped nonzero rate points along the move
  a_rate_sign: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive.saturated && (drive.desired_rate != '0)
      |-> (drive.desired_rate[31] == span_neg))
    else $error("desired rate sign disagrees with move direction");
`endif

endmodule

// ===== sv/pdct_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Divides {dividend_hi, dividend_lo} by divisor where dividend_hi < divisor.
// Depends on pdct_pkg.
module pdct_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              item_valid,
  input  logic [31:0]       dividend_hi,
  input  logic [31:0]       dividend_lo,
  input  logic [31:0]       divisor,
  input  pdct_pkg::side_t   tag,
  output logic              quot_valid,
  output logic [31:0]       quotient,
  output pdct_pkg::side_t   quot_tag
);
  import pdct_pkg::*;

  // One step: shift in a dividend bit, subtract if it fits
  function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] lq,
                                           input logic [31:0] dvs);
    logic [32:0] r2;
    logic [33:0] trial;
    logic        ge;
    r2    = {rem, lq[31]};
    trial = {1'b0, r2} - {2'b00, dvs};
    ge    = !trial[33];
    return {(ge ? trial[31:0] : r2[31:0]), lq[30:0], ge};
  endfunction

  logic [DIV_STEPS-1:0] vld;
  logic [63:0]          stg      [DIV_STEPS];
  logic [63:0]          stg_next [DIV_STEPS];
  side_t                side     [DIV_STEPS];

  // Work out every stage's step; upper half is the remainder
  always_comb begin
    stg_next[0] = div_step(dividend_hi, dividend_lo, divisor);
    for (int k = 1; k < DIV_STEPS; k++) begin
      stg_next[k] = div_step(stg[k-1][63:32], stg[k-1][31:0], divisor);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], item_valid};
    end
  end

  // Advance remainders, quotient bits and tags
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        stg[k] <= stg_next[k];
      end
      side[0] <= tag;
      for (int k = 1; k < DIV_STEPS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign quot_valid = vld[DIV_STEPS-1];
  assign quotient   = stg[DIV_STEPS-1][31:0];
  assign quot_tag   = side[DIV_STEPS-1];

`ifndef SYNTHESIS
  // The upper dividend must already be reduced, or the quotient overflows
  a_hi_reduced: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (divisor == '0) || (dividend_hi < divisor))
    else $error("divider entered with upper dividend not below divisor");
`endif

endmodule

// ===== test/pdct_drive_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PD controller core: mirrors its registers from the APB writes,
// predicts one drive word per accepted sample word and compares in order.
// Depends on pdct_pkg for the word types, register indexes and reset values.
module pdct_drive_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  input  logic                         sample_stall,
  input  pdct_pkg::sample_t            sample,
  input  logic                         drive_valid,
  input  logic                         drive_stall,
  input  pdct_pkg::drive_t             drive,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [pdct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fails,
  output int                           taken,
  output int                           given,
  output int                           clipped,
  output int                           held_cycles
);
  import pdct_pkg::*;

  localparam longint TOP32 = 64'sd2147483647;
  localparam longint BOT32 = -64'sd2147483648;

  // Register mirror
  logic        [30:0] kp_gain;
  logic        [30:0] kv_gain;
  logic        [31:0] move_time;
  logic signed [31:0] from_angle;
  logic signed [31:0] to_angle;

  // Drive words still owed by the block, oldest first
  drive_t due [$];

  function automatic longint clamp32(longint v);
    if (v > TOP32) return TOP32;
    if (v < BOT32) return BOT32;
    return v;
  endfunction

  // sign(e) * floor(k*|e| / 2^FRAC_BITS)
  function automatic longint gain_product(logic [30:0] k, longint e);
    logic [63:0] p;
    p = ({33'd0, k} * ((e < 0) ? 64'(-e) : 64'(e))) >> FRAC_BITS;
    return (e < 0) ? -$signed(p) : $signed(p);
  endfunction

  // Cubic set point and PD drive for one sample word
  function automatic drive_t plan_drive(sample_t w);
    longint      q, qd, q0, qf, d, pos, vel, tq, h, unit;
    logic [63:0] t, ft, m, s, s2, s3, g, pm, vm;
    bit          clip;
    drive_t      r;
    clip = 1'b0;
    unit = 64'sd1 << Q30_BITS;
    t    = {32'd0, w.now_time};
    ft   = {32'd0, move_time};
    q    = $signed(w.measured_angle);
    qd   = $signed(w.measured_rate);
    q0   = from_angle;
    qf   = to_angle;
    d    = qf - q0;
    m    = (d < 0) ? -d : d;
    // Zero duration or past the end: hold the target at rest
    if (ft == 0 || t > ft) begin
      pos = qf;
      vel = 0;
    end else begin
      s  = (t << Q30_BITS) / ft;
      s2 = (s * s) >> Q30_BITS;
      s3 = (s2 * s) >> Q30_BITS;
      h  = 3 * $signed(s2) - 2 * $signed(s3);
      if (h < 0) h = 0;
      if (h > unit) h = unit;
      pm  = (m * h) >> Q30_BITS;
      pos = (d < 0) ? q0 - $signed(pm) : q0 + $signed(pm);
      g   = (s * (unit - s)) >> Q30_BITS;
      vm  = ((64'd6 * m * g) / ft) >> (Q30_BITS - FRAC_BITS);
      vel = (d < 0) ? -$signed(vm) : $signed(vm);
      if (clamp32(vel) != vel) clip = 1'b1;
      vel = clamp32(vel);
    end
    tq = gain_product(kp_gain, pos - q) + gain_product(kv_gain, vel - qd);
    if (clamp32(tq) != tq) clip = 1'b1;
    tq = clamp32(tq);
    r.drive_torque  = tq[31:0];
    r.desired_angle = pos[31:0];
    r.desired_rate  = vel[31:0];
    r.saturated     = clip;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      kp_gain    = PROP_GAIN_RST;
      kv_gain    = DERIV_GAIN_RST;
      move_time  = FINAL_TIME_RST;
      from_angle = START_ANGLE_RST;
      to_angle   = TARGET_ANGLE_RST;
      due.delete();
    end else begin
      // Track register writes; slots past the list are dropped
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_PROP_GAIN:    kp_gain    = pwdata[30:0];
          REG_DERIV_GAIN:   kv_gain    = pwdata[30:0];
          REG_FINAL_TIME:   move_time  = pwdata;
          REG_START_ANGLE:  from_angle = pwdata;
          REG_TARGET_ANGLE: to_angle   = pwdata;
          default: ;
        endcase
      end
      // Predict on every accepted sample word
      if (sample_valid && !sample_stall) begin
        due.push_back(plan_drive(sample));
        taken <= taken + 1;
      end
      if (sample_valid && sample_stall) held_cycles <= held_cycles + 1;
      // Compare each accepted drive word with the oldest prediction
      if (drive_valid && !drive_stall) begin
        given <= given + 1;
        if (drive.saturated) clipped <= clipped + 1;
        if (due.size() == 0) begin
          fails++;
          $display("%0t: drive word with nothing pending: expected none, got %h",
                   $time, drive);
        end else begin
          want = due.pop_front();
          check_field("drive_torque", want.drive_torque, drive.drive_torque);
          check_field("desired_angle", want.desired_angle, drive.desired_angle);
          check_field("desired_rate", want.desired_rate, drive.desired_rate);
          check_field("saturated", {31'd0, want.saturated}, {31'd0, drive.saturated});
        end
      end
    end
  end

endmodule

// ===== test/pd_controller_cubic_trajectory_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the PD controller core: drives set-point and random sample
// words and APB register settings, with random gaps and stalls on both sides.
// Depends on pdct_pkg, the core and pdct_drive_checker.
module pd_controller_cubic_trajectory_core_tb;
  import pdct_pkg::*;

  localparam int PHASES      = 10;
  localparam int PER_PHASE   = 143;
  localparam int SET_POINTS  = 11;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  // First slot past the register file
  localparam logic [REG_IDX_W-1:0] UNUSED_SLOT = 3'd5;

  logic               clk = 1'b0;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  sample_t            sample;
  logic               drive_valid;
  logic               drive_stall;
  drive_t             drive;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fails, taken, given, clipped, held_cycles;

  bit          hold_req = 1'b0;
  logic [31:0] ft_cur   = FINAL_TIME_RST;

  pd_controller_cubic_trajectory_core uut (.*);

  pdct_drive_checker watch (.*);

  always #5 clk = ~clk;

  // Sender gap: mostly none or short, now and then long
  function automatic int pause(bit gappy);
    int r;
    if (!gappy) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [31:0] pick_angle();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return 32'($urandom_range(32'h0010_0000, 0)) - 32'h0008_0000;
    if (r < 80) return $urandom;
    if (r < 90) return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return 32'h0;
  endfunction

  function automatic logic [31:0] pick_gain();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(32'h0008_0000, 0);
    if (r < 80) return 32'h0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_span();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return $urandom_range(32'h0004_0000, 32'h0000_0100);
    if (r < 75) return $urandom_range(255, 1);
    return $urandom;
  endfunction

  // Times mostly inside the move, with its ends and overruns
  function automatic sample_t pick_sample();
    int      r;
    sample_t w;
    r = $urandom_range(99, 0);
    if (r < 60)      w.now_time = (ft_cur == 0) ? $urandom : $urandom_range(ft_cur, 0);
    else if (r < 68) w.now_time = ft_cur;
    else if (r < 74) w.now_time = 32'h0;
    else if (r < 84) w.now_time = ft_cur + $urandom_range(3, 1);
    else             w.now_time = $urandom;
    w.measured_angle = pick_angle();
    w.measured_rate  = pick_angle();
    return w;
  endfunction

  // Offer one sample word and hold it until taken, then idle for the gap
  task automatic offer(sample_t w, int gap);
    sample       <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic probe(logic [31:0] t, logic [31:0] a, logic [31:0] r);
    sample_t w;
    w.now_time       = t;
    w.measured_angle = a;
    w.measured_rate  = r;
    offer(w, pause(1'b1));
  endtask

  // Drop valid and wait until every drive word is back
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (taken != given);
  endtask

  // APB write: setup cycle, then access until ready
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_move(logic [31:0] kp, logic [31:0] kv, logic [31:0] ft,
                          logic [31:0] from, logic [31:0] to);
    reg_write(REG_PROP_GAIN, kp);
    reg_write(REG_DERIV_GAIN, kv);
    reg_write(REG_FINAL_TIME, ft);
    reg_write(REG_START_ANGLE, from);
    reg_write(REG_TARGET_ANGLE, to);
    ft_cur = ft;
  endtask

  // Receiver: runs, short stalls, rare long ones, and one long hold-off
  initial begin : drain_side
    bit held;
    int r;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        drive_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(9, 0);
        if (r < 6) begin
          drive_stall <= 1'b0;
          repeat ($urandom_range(30, 1)) @(posedge clk);
        end else if (r < 9) begin
          drive_stall <= 1'b1;
          repeat ($urandom_range(3, 1)) @(posedge clk);
        end else begin
          drive_stall <= 1'b1;
          repeat ($urandom_range(50, 10)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] a0, a1;
    bit          gappy;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Set points under the reset registers: ends of the move, overrun, clipping
    probe(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    probe(32'h0000_4000, 32'h0001_0000, 32'h0000_0000);
    probe(32'h0000_8000, TARGET_ANGLE_RST, 32'h0000_0000);
    probe(32'h0000_8001, 32'h0000_0000, 32'h0000_0000);
    probe(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    probe(32'h0000_2000, 32'h7FFF_FFFF, 32'h8000_0000);
    probe(32'h0000_6000, 32'h8000_0000, 32'h7FFF_FFFF);
    probe(32'h0000_4000, 32'h8000_0000, 32'h8000_0000);
    probe(32'h0000_4000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    probe(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    probe(32'h0000_7FFF, 32'h0003_243F, 32'h0000_0001);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // Widest move, longest time, gains with the top bit set to be masked
        0: set_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF);
        // Falling move over the shortest time, gains off
        1: set_move(32'h0, 32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
        // Zero duration, plus a write past the register file
        2: begin
          set_move(pick_gain(), pick_gain(), 32'h0, pick_angle(), pick_angle());
          reg_write(UNUSED_SLOT, $urandom);
        end
        // Very fast wide move: the rate clips
        3: set_move(pick_gain(), pick_gain(), 32'h2, 32'h8000_0000, 32'h7FFF_FFFF);
        default: begin
          a0 = pick_angle();
          a1 = ($urandom_range(9, 0) == 0) ? a0 : pick_angle();
          set_move(pick_gain(), pick_gain(), pick_span(), a0, a1);
        end
      endcase
      gappy = (ph % 3 != 2) && (ph != 5);
      // Hold the receiver off while words keep coming
      if (ph == 5) hold_req <= 1'b1;
      for (int n = 0; n < PER_PHASE; n++) offer(pick_sample(), pause(gappy));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d sample words (%0d set points) over %0d register settings;",
             taken, SET_POINTS, PHASES + 1);
    $display("%0d drive words compared, %0d clipped, input stalled on %0d cycles.",
             given, clipped, held_cycles);
    if (fails == 0 && taken == given) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d drive words outstanding", taken - given);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== pd_controller_cubic_trajectory_core.f =====
sv/pdct_pkg.sv
sv/pdct_div.sv
sv/pd_controller_cubic_trajectory_core.sv
test/pdct_drive_checker.sv
test/pd_controller_cubic_trajectory_core_tb.sv
